@@ sv/kpiq_pkg.sv @@
package kpiq_pkg;

  // Calibration table geometry.
  localparam int ROBOTS = 12;
  localparam logic [3:0] MAX_ID = 4'd11;
  localparam int KICK_LIMIT = 150;
  localparam int CHIP_LIMIT = 500;
  localparam int OUT_LIMIT = 100;

  // Square root chain: a 40-bit discriminant gives a 20-bit root, one bit per cell.
  localparam int RAD_W = 40;
  localparam int ROOT_W = 20;
  localparam int REM_W = 22;
  localparam int SQ_CELLS = ROOT_W;

  // Curve coefficients: a and b in units of 1e-4, c in units of 1e-3.
  localparam int KICK_A_DEC [ROBOTS] = '{-1012, -988, -1012, -900, -789, -859, -857,
                                          -813, -813, -813, -813, -813};
  localparam int KICK_B_DEC [ROBOTS] = '{68441, 65467, 68645, 62632, 48728, 62805, 62963,
                                          61029, 61029, 61029, 61029, 61029};
  localparam int KICK_C_DEC [ROBOTS] = '{-27822, -28173, -28968, -22909, -18189, -27016,
                                          -25360, -21593, -21593, -21593, -21593, -21593};
  localparam int CHIP_A_DEC [ROBOTS] = '{-586, -845, -533, -401, -800, -533, -953, -291,
                                          -533, -533, -263, -926};
  localparam int CHIP_B_DEC [ROBOTS] = '{76894, 120510, 90368, 86320, 108040, 90368,
                                          125550, 70266, 90368, 90368, 53907, 126100};
  localparam int CHIP_C_DEC [ROBOTS] = '{-121180, -197310, -164510, -139310, -166690,
                                          -164510, -195920, -103610, -164510, -164510,
                                          -84211, -203720};

  // Tag that travels with every word through the pipeline.
  typedef struct packed {
    logic       kind;
    logic [3:0] id;
    logic       zero;
  } tag_t;

  // Per-curve constants in Q.16: -4a, -c, b and b squared (Q.32).
  typedef struct packed {
    logic [14:0] a4n;
    logic [24:0] cmag;
    logic [19:0] b;
    logic [39:0] bsq;
  } coef_t;

  // Word handed from one square root cell to the next.
  typedef struct packed {
    tag_t              tag;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // Rounds the decimal coefficients to Q.16, ties away from zero.
  function automatic coef_t mk_coef(bit chip, int idx);
    longint ad;
    longint bd;
    longint cd;
    longint aq;
    longint bq;
    longint cq;
    coef_t  r;
    ad = chip ? CHIP_A_DEC[idx] : KICK_A_DEC[idx];
    bd = chip ? CHIP_B_DEC[idx] : KICK_B_DEC[idx];
    cd = chip ? CHIP_C_DEC[idx] : KICK_C_DEC[idx];
    aq = (longint'(-ad) * 65536 + 5000) / 10000;
    bq = (longint'(bd) * 65536 + 5000) / 10000;
    cq = (longint'(-cd) * 65536 + 500) / 1000;
    r.a4n = 15'(4 * aq);
    r.cmag = 25'(cq);
    r.b = 20'(bq);
    r.bsq = 40'(bq * bq);
    return r;
  endfunction

  // Floor integer square root, used only on constants.
  function automatic logic [16:0] isqrt_c(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bw;
    rem = v;
    res = '0;
    bw = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return 17'(res);
  endfunction

  localparam coef_t COEF [2][ROBOTS] = '{
    '{mk_coef(0, 0), mk_coef(0, 1), mk_coef(0, 2), mk_coef(0, 3), mk_coef(0, 4),
      mk_coef(0, 5), mk_coef(0, 6), mk_coef(0, 7), mk_coef(0, 8), mk_coef(0, 9),
      mk_coef(0, 10), mk_coef(0, 11)},
    '{mk_coef(1, 0), mk_coef(1, 1), mk_coef(1, 2), mk_coef(1, 3), mk_coef(1, 4),
      mk_coef(1, 5), mk_coef(1, 6), mk_coef(1, 7), mk_coef(1, 8), mk_coef(1, 9),
      mk_coef(1, 10), mk_coef(1, 11)}
  };

  // Magnitude of 1/(2a) in Q.16; a is negative, so the true value is the negation.
  localparam logic [20:0] INV2A_MAG [2][ROBOTS] = '{
    '{21'((64'd655360000 + 64'd1012) / 64'd2024), 21'((64'd655360000 + 64'd988) / 64'd1976),
      21'((64'd655360000 + 64'd1012) / 64'd2024), 21'((64'd655360000 + 64'd900) / 64'd1800),
      21'((64'd655360000 + 64'd789) / 64'd1578), 21'((64'd655360000 + 64'd859) / 64'd1718),
      21'((64'd655360000 + 64'd857) / 64'd1714), 21'((64'd655360000 + 64'd813) / 64'd1626),
      21'((64'd655360000 + 64'd813) / 64'd1626), 21'((64'd655360000 + 64'd813) / 64'd1626),
      21'((64'd655360000 + 64'd813) / 64'd1626), 21'((64'd655360000 + 64'd813) / 64'd1626)},
    '{21'((64'd655360000 + 64'd586) / 64'd1172), 21'((64'd655360000 + 64'd845) / 64'd1690),
      21'((64'd655360000 + 64'd533) / 64'd1066), 21'((64'd655360000 + 64'd401) / 64'd802),
      21'((64'd655360000 + 64'd800) / 64'd1600), 21'((64'd655360000 + 64'd533) / 64'd1066),
      21'((64'd655360000 + 64'd953) / 64'd1906), 21'((64'd655360000 + 64'd291) / 64'd582),
      21'((64'd655360000 + 64'd533) / 64'd1066), 21'((64'd655360000 + 64'd533) / 64'd1066),
      21'((64'd655360000 + 64'd263) / 64'd526), 21'((64'd655360000 + 64'd926) / 64'd1852)}
  };

  // Chip scale sqrt(k1 / k_id) in Q.16.
  localparam logic [16:0] CHIP_SCALE [ROBOTS] = '{
    isqrt_c((64'd260 << 32) / 64'd220), isqrt_c((64'd260 << 32) / 64'd260),
    isqrt_c((64'd260 << 32) / 64'd180), isqrt_c((64'd260 << 32) / 64'd250),
    isqrt_c((64'd260 << 32) / 64'd210), isqrt_c((64'd260 << 32) / 64'd200),
    isqrt_c((64'd260 << 32) / 64'd150), isqrt_c((64'd260 << 32) / 64'd200),
    isqrt_c((64'd260 << 32) / 64'd265), isqrt_c((64'd260 << 32) / 64'd265),
    isqrt_c((64'd260 << 32) / 64'd140), isqrt_c((64'd260 << 32) / 64'd180)
  };

endpackage

@@ sv/kpiq_front.sv @@
module kpiq_front import kpiq_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  logic              kind_i,
  input  logic [3:0]        robot_id_i,
  input  logic signed [17:0] raw_power_i,
  output logic              ready_o,
  input  logic              take_i,
  output logic              out_vld_o,
  output sq_t               out_o
);

  localparam int SHIFT = 16 - FRAC_BITS;

  logic              v1_q, v2_q, v3_q;
  logic              ld1, ld2, ld3;
  tag_t              tag1_q, tag2_q, tag3_q;
  tag_t              tag1_d;
  logic [25:0]       p1_q, p1_d;
  logic [40:0]       prod2_q, prod2_d;
  logic [RAD_W-1:0]  dlt3_q, dlt3_d;
  logic [31:0]       limit, mag, clamped;
  coef_t             co;
  logic [25:0]       pmc;
  logic [41:0]       diff;

  // Each stage loads when it is empty or its word moves on.
  assign ld3 = !v3_q || take_i;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ready_o = ld1;

  // Stage one: saturate the id and clamp the power into Q.16.
  always_comb begin
    tag1_d.kind = kind_i;
    tag1_d.id = (robot_id_i > MAX_ID) ? MAX_ID : robot_id_i;
    tag1_d.zero = raw_power_i[17] || (raw_power_i == '0);
    limit = 32'(kind_i ? CHIP_LIMIT : KICK_LIMIT) << FRAC_BITS;
    mag = {15'd0, raw_power_i[16:0]};
    clamped = (mag > limit) ? limit : mag;
    p1_d = 26'(clamped << SHIFT);
  end

  // Stage two: -4a times (p - c).
  always_comb begin
    co = COEF[tag1_q.kind][tag1_q.id];
    pmc = p1_q + 26'(co.cmag);
    prod2_d = 41'(co.a4n) * 41'(pmc);
  end

  // Stage three: discriminant, clipped at zero.
  always_comb begin
    diff = 42'(COEF[tag2_q.kind][tag2_q.id].bsq) - 42'(prod2_q);
    dlt3_d = diff[41] ? '0 : diff[RAD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_vld_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      tag1_q <= tag1_d;
      p1_q <= p1_d;
    end
    if (ld2) begin
      tag2_q <= tag1_q;
      prod2_q <= prod2_d;
    end
    if (ld3) begin
      tag3_q <= tag2_q;
      dlt3_q <= dlt3_d;
    end
  end

  assign out_vld_o = v3_q;
  assign out_o = '{tag: tag3_q, rad: dlt3_q, rem: '0, root: '0};

endmodule

@@ sv/kpiq_sqrt_cell.sv @@
module kpiq_sqrt_cell import kpiq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_vld_i,
  input  sq_t  in_i,
  output logic ready_o,
  input  logic take_i,
  output logic out_vld_o,
  output sq_t  out_o
);

  logic        v_q;
  logic        ld;
  sq_t         w_q, w_d;
  logic [REM_W:0] r2, trial;

  assign ld = !v_q || take_i;
  assign ready_o = ld;

  // One root bit: bring down two radicand bits and try to subtract.
  // The remainder never exceeds twice the root, so its top bit is always clear.
  always_comb begin
    r2 = {in_i.rem[REM_W-2:0], in_i.rad[RAD_W-1 -: 2]};
    trial = (REM_W + 1)'({in_i.root, 2'b01});
    w_d.tag = in_i.tag;
    w_d.rad = {in_i.rad[RAD_W-3:0], 2'b00};
    if (r2 >= trial) begin
      w_d.rem = REM_W'(r2 - trial);
      w_d.root = {in_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      w_d.rem = REM_W'(r2);
      w_d.root = {in_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) w_q <= w_d;
  end

  assign out_vld_o = v_q;
  assign out_o = w_q;

endmodule

@@ sv/kpiq_back.sv @@
module kpiq_back import kpiq_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_vld_i,
  input  sq_t         in_i,
  output logic        ready_o,
  input  logic        stall_i,
  output logic        out_vld_o,
  output logic [14:0] power_o
);

  localparam int SHIFT = 16 - FRAC_BITS;
  localparam int HALF = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
  localparam logic [31:0] LIMIT = 32'(OUT_LIMIT) << FRAC_BITS;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               ld1, ld2, ld3, ld4;
  tag_t               tag1_q, tag2_q, tag3_q;
  logic signed [42:0] prod1_q, prod1_d;
  logic [25:0]        x2_q, x2_d;
  logic [25:0]        x3_q, x3_d;
  logic [14:0]        y4_q, y4_d;
  logic signed [20:0] diff;
  logic [42:0]        sum;
  logic [42:0]        scaled;
  logic [31:0]        y;

  assign ld4 = !v4_q || !stall_i;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ready_o = ld1;

  // Stage one: (b - root) times |1/(2a)|, the same as (root - b) / (2a).
  always_comb begin
    diff = $signed({1'b0, COEF[in_i.tag.kind][in_i.tag.id].b}) -
           $signed({1'b0, in_i.root});
    prod1_d = 43'(diff) * 43'($signed({1'b0, INV2A_MAG[in_i.tag.kind][in_i.tag.id]}));
  end

  // Stage two: round to Q.16; a non-positive quotient gives zero.
  always_comb begin
    sum = 43'(prod1_q) + 43'd32768;
    x2_d = (prod1_q <= 0) ? '0 : 26'(sum[42:16]);
  end

  // Stage three: chip scaling.
  always_comb begin
    scaled = 43'(x2_q) * 43'(CHIP_SCALE[tag2_q.id]) + 43'd32768;
    x3_d = tag2_q.kind ? 26'(scaled[42:16]) : x2_q;
  end

  // Stage four: move to the port format and clamp to full power; a word tagged zero gives zero.
  always_comb begin
    y = (32'(x3_q) + 32'(HALF)) >> SHIFT;
    if (y > LIMIT) y = LIMIT;
    y4_d = tag3_q.zero ? '0 : y[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_vld_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      tag1_q <= in_i.tag;
      prod1_q <= prod1_d;
    end
    if (ld2) begin
      tag2_q <= tag1_q;
      x2_q <= x2_d;
    end
    if (ld3) begin
      tag3_q <= tag2_q;
      x3_q <= x3_d;
    end
    if (ld4) y4_q <= y4_d;
  end

  assign out_vld_o = v4_q;
  assign power_o = y4_q;

endmodule

@@ sv/kick_power_inverse_quadratic.sv @@
// Calibrated kicker power.
// A command word (kind, robot id, requested power with FRAC_BITS fractional
// bits) enters on in_valid_i / in_stall_o. The block inverts the robot's
// quadratic kick or chip curve and returns the actuator power, 0 to 100 with
// FRAC_BITS fractional bits, on out_valid_o / out_stall_i.
// Every word gives exactly one result word, in order.
// The pipeline has three front stages (clamp, multiply, discriminant), a
// chain of 20 square root cells at one root bit each, and four back stages
// (divide by 2a as a multiply, rounding, chip scaling, output register).
// Throughput is one word per cycle unless the receiver stalls; every stage
// holds its own valid bit. When the receiver stalls, the output register
// holds its word and the stages behind it keep filling their empty slots;
// in_stall_o rises only once the whole pipeline is full.
// Reset clears all valid bits; the block holds no other state.
module kick_power_inverse_quadratic import kpiq_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [3:0]         robot_id_i,
  input  logic signed [17:0] raw_power_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [14:0]        calibrated_power_o
);

  logic front_ready;
  logic lnk_vld [SQ_CELLS+1];
  sq_t  lnk_dat [SQ_CELLS+1];
  logic lnk_rdy [SQ_CELLS+1];

  assign in_stall_o = !front_ready;

  // Discriminant pipeline.
  kpiq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_valid_i),
    .kind_i     (kind_i),
    .robot_id_i (robot_id_i),
    .raw_power_i(raw_power_i),
    .ready_o    (front_ready),
    .take_i     (lnk_rdy[0]),
    .out_vld_o  (lnk_vld[0]),
    .out_o      (lnk_dat[0])
  );

  // Square root chain, one bit per cell.
  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
    kpiq_sqrt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .in_vld_i (lnk_vld[g]),
      .in_i     (lnk_dat[g]),
      .ready_o  (lnk_rdy[g]),
      .take_i   (lnk_rdy[g+1]),
      .out_vld_o(lnk_vld[g+1]),
      .out_o    (lnk_dat[g+1])
    );
  end

  // Quotient, chip scaling and output formatting.
  kpiq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (lnk_vld[SQ_CELLS]),
    .in_i     (lnk_dat[SQ_CELLS]),
    .ready_o  (lnk_rdy[SQ_CELLS]),
    .stall_i  (out_stall_i),
    .out_vld_o(out_valid_o),
    .power_o  (calibrated_power_o)
  );

endmodule

@@ tb/kpiq_checker.sv @@
// Watches both channels of the kicker power block, predicts each result word
// from its command word and compares them in order.
module kpiq_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               kind_i,
  input  logic [3:0]         robot_id_i,
  input  logic signed [17:0] raw_power_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [14:0]        calibrated_power_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int ROBOTS = 12;
  localparam int MAX_ID = 11;

  // Calibration rows: a and b in 1e-4, c in 1e-3, chip constant k.
  localparam int KA [ROBOTS] = '{-1012, -988, -1012, -900, -789, -859, -857, -813, -813,
                                 -813, -813, -813};
  localparam int KB [ROBOTS] = '{68441, 65467, 68645, 62632, 48728, 62805, 62963, 61029,
                                 61029, 61029, 61029, 61029};
  localparam int KC [ROBOTS] = '{-27822, -28173, -28968, -22909, -18189, -27016, -25360,
                                 -21593, -21593, -21593, -21593, -21593};
  localparam int CA [ROBOTS] = '{-586, -845, -533, -401, -800, -533, -953, -291, -533,
                                 -533, -263, -926};
  localparam int CB [ROBOTS] = '{76894, 120510, 90368, 86320, 108040, 90368, 125550,
                                 70266, 90368, 90368, 53907, 126100};
  localparam int CC [ROBOTS] = '{-121180, -197310, -164510, -139310, -166690, -164510,
                                 -195920, -103610, -164510, -164510, -84211, -203720};
  localparam int CK [ROBOTS] = '{220, 260, 180, 250, 210, 200, 150, 200, 265, 265, 140, 180};

  logic [14:0] power_q[$];
  int          fails;

  // Rounds num / den to Q.16 with ties away from zero.
  function automatic longint round_q16(longint num, longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag * 65536 + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  // Floor integer square root.
  function automatic longint floor_sqrt(longint v);
    longint res;
    longint bw;
    res = 0;
    bw = 64'sd1 << 62;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= res + bw) begin
        v = v - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  // Inverts the robot's curve and returns the clamped actuator power.
  function automatic logic [14:0] calibrate(logic chip, logic [3:0] rid,
                                            logic signed [17:0] req);
    longint raw, lim, ad, a, b, c, inv, p, delta, s, prod, x, y, scale;
    int     id;
    raw = req;
    if (raw <= 0) return '0;
    id = rid > MAX_ID ? MAX_ID : rid;
    lim = (chip ? 500 : 150) * (64'sd1 << FRAC_BITS);
    if (raw > lim) raw = lim;
    p = raw <<< (16 - FRAC_BITS);
    ad = chip ? CA[id] : KA[id];
    a = round_q16(ad, 10000);
    b = round_q16(chip ? CB[id] : KB[id], 10000);
    c = round_q16(chip ? CC[id] : KC[id], 1000);
    inv = round_q16(-10000, -2 * ad);
    delta = b * b - 4 * a * (c - p);
    if (delta < 0) delta = 0;
    s = floor_sqrt(delta);
    prod = (s - b) * inv;
    if (prod <= 0) return '0;
    x = (prod + 32768) >>> 16;
    if (chip) begin
      scale = floor_sqrt((longint'(CK[1]) <<< 32) / CK[id]);
      x = (x * scale + 32768) >>> 16;
    end
    y = FRAC_BITS < 16 ? (x + (64'sd1 << (15 - FRAC_BITS))) >>> (16 - FRAC_BITS) : x;
    if (y > (100 << FRAC_BITS)) y = 100 << FRAC_BITS;
    return 15'(y);
  endfunction

  // Record the expectation for each accepted command word and check each result word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        power_q.push_back(calibrate(kind_i, robot_id_i, raw_power_i));
      if (out_valid_i && !out_stall_i) begin
        if (power_q.size() == 0) begin
          $error("unexpected result word calibrated_power=%0d", calibrated_power_i);
          fails++;
        end else if (power_q[0] !== calibrated_power_i) begin
          $error("calibrated_power mismatch: expected %0d, actual %0d",
                 power_q[0], calibrated_power_i);
          fails++;
          void'(power_q.pop_front());
        end else begin
          void'(power_q.pop_front());
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o = power_q.size();

endmodule

@@ tb/testbench.sv @@
// Drives command words into the kicker power block with random gaps and
// receiver stalls; the checker predicts and compares.
module testbench;

  localparam int WATCHDOG = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic [3:0]         robot_id;
  logic signed [17:0] raw_power;
  logic               out_valid;
  logic               out_stall;
  logic [14:0]        calibrated_power;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  bit                 sending;

  kick_power_inverse_quadratic i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .robot_id_i(robot_id), .raw_power_i(raw_power),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .calibrated_power_o(calibrated_power)
  );

  kpiq_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .robot_id_i(robot_id), .raw_power_i(raw_power),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .calibrated_power_i(calibrated_power), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one command word and waits until it is accepted; valid stays high
  // into a following word when there is no gap.
  task automatic send_word(logic k, logic [3:0] id, logic signed [17:0] pw);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    robot_id <= id;
    raw_power <= pw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls, in bursts, with quiet stretches.
  initial begin
    int g;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      g = gap_len();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= g != 0;
        repeat (g + 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog on accepted words.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !sending && pending == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [17:0] pw;
    int                 r;
    in_valid <= 1'b0;
    kind <= 1'b0;
    robot_id <= '0;
    raw_power <= '0;
    sending = 1'b1;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and negative power, extremes, clamps, every robot, id saturation.
    send_word(1'b0, 4'd0, 18'sd0);
    send_word(1'b1, 4'd3, -18'sd1);
    send_word(1'b0, 4'd15, -18'sd131072);
    send_word(1'b1, 4'd15, 18'sd131071);
    send_word(1'b0, 4'd12, 18'sd131071);
    send_word(1'b0, 4'd5, 18'sd1);
    send_word(1'b1, 4'd6, 18'sd1);
    send_word(1'b0, 4'd2, 18'sd38400);
    send_word(1'b0, 4'd2, 18'sd38401);
    send_word(1'b1, 4'd10, 18'sd128000);
    send_word(1'b1, 4'd10, 18'sd128001);
    send_word(1'b0, 4'd4, 18'sd20000);
    send_word(1'b1, 4'd7, 18'sd60000);
    for (int i = 0; i < 12; i++) send_word(i[0], i[3:0], 18'(3000 + i * 6000));

    // Random commands, mostly within the useful range.
    for (int n = 0; n < 1400; n++) begin
      r = $urandom_range(0, 9);
      if (r == 0) pw = 18'($urandom);
      else if (r == 1) pw = 18'($urandom_range(0, 50)) - 18'sd20;
      else pw = 18'($urandom_range(1, 128000));
      send_word(1'($urandom), 4'($urandom), pw);
    end
    in_valid <= 1'b0;

    sending = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/kpiq_pkg.sv
sv/kpiq_front.sv
sv/kpiq_sqrt_cell.sv
sv/kpiq_back.sv
sv/kick_power_inverse_quadratic.sv
tb/kpiq_checker.sv
tb/testbench.sv
